@@ hdl/wbps_pkg.sv @@
// Package: shared constants and register codes of the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 16;
   localparam int POSITION_BITS_DEF     = 32;
   localparam int PATTERN_REG_BYTES     = 16;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int ADDRESS_WIDTH   = 64;
   localparam int OFFSET_WIDTH    = 32;
   localparam int CARE_WIDTH      = 16;
   localparam int LENGTH_WIDTH    = 5;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_CARE_MASK    = 3'd2,
      REG_PATTERN_LEN  = 3'd3,
      REG_REGION_BASE  = 3'd4,
      REG_RESULT_OFFS  = 3'd5
   } csr_reg_type;

endpackage

@@ hdl/wbps_req_if.sv @@
// Interface: input byte channel.
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/wbps_rsp_if.sv @@
// Interface: result channel.
interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [63:0] match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface

@@ hdl/wbps_csr_if.sv @@
// Interface: configuration write channel.
interface wbps_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/wildcard_byte_pattern_scanner_unit.sv @@
// Top level: wildcard byte pattern scanner.
//
// Bytes of a region arrive on req_bus, one per transfer, last_byte on the final one.
// The first start position whose bytes match the pattern (care mask clear = wildcard)
// gives one rsp_bus transfer with found=1 and base + start + offset. A region that
// ends without a match gives found=0 with a zero address on its last byte.
// Configuration is written through csr_bus (always ready); the user must do so only while
// the block is idle, which the block itself does not enforce. An accepted byte is held in
// the input register; its result is then loaded into the result register, which drives
// rsp valid.
// Throughput: one byte per cycle unless a result stalls; the window compare and the
// address add sit in one stage between the input and result registers.
// A stalled receiver holds the pending result; the input register then keeps its byte
// and req_bus.ready drops until the result is taken.
// Reset (synchronous) empties both registers, clears the region state and loads the
// register reset values: empty pattern, length one, zero base and offset.
module wildcard_byte_pattern_scanner_unit #(
   parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
   parameter int POSITION_BITS     = wbps_pkg::POSITION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wbps_req_if.sink    req_bus,
   wbps_rsp_if.source  rsp_bus,
   wbps_csr_if.sink    csr_bus
);
   import wbps_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int CL_W  = (LEN_W > LENGTH_WIDTH) ? LEN_W : LENGTH_WIDTH;
   localparam int CMP_W = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
   localparam int WIN_W = MAX_PATTERN_BYTES * 8;

   logic [63:0]              pat_low_ff, pat_high_ff, base_ff;
   logic [CARE_WIDTH-1:0]    care_ff;
   logic [LENGTH_WIDTH-1:0]  plen_ff;
   logic [OFFSET_WIDTH-1:0]  offs_ff;

   logic                     in_valid_ff, in_last_ff;
   logic [7:0]               in_byte_ff;

   logic [WIN_W-1:0]         win_ff, win_in, win_rev, aligned;
   logic [POSITION_BITS-1:0] seen_ff, seen_in;
   logic                     reported_ff, reported_in;

   logic                     out_valid_ff, out_found_ff;
   logic [ADDRESS_WIDTH-1:0] out_addr_ff;

   logic [WIN_W-1:0]             pat_vec;
   logic [MAX_PATTERN_BYTES-1:0] care_vec, ok_vec;
   logic [CL_W-1:0]              plen_ext;
   logic [LEN_W-1:0]             used_len, shift;
   logic                         process, hit, fire, not_found;
   logic [ADDRESS_WIDTH-1:0]     addr;

   // configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
         plen_ff     <= LENGTH_WIDTH'(1);
         base_ff     <= '0;
         offs_ff     <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_PATTERN_LOW:  pat_low_ff  <= csr_bus.data;
            REG_PATTERN_HIGH: pat_high_ff <= csr_bus.data;
            REG_CARE_MASK:    care_ff     <= csr_bus.data[CARE_WIDTH-1:0];
            REG_PATTERN_LEN:  plen_ff     <= csr_bus.data[LENGTH_WIDTH-1:0];
            REG_REGION_BASE:  base_ff     <= csr_bus.data;
            REG_RESULT_OFFS:  offs_ff     <= csr_bus.data[OFFSET_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // pattern bytes beyond the register pair are wildcards
   genvar gk;
   generate
      for (gk = 0; gk < MAX_PATTERN_BYTES; gk++) begin : g_pat
         if (gk < PATTERN_REG_BYTES) begin : g_reg
            if (gk < 8) begin : g_lo
               assign pat_vec[gk*8 +: 8] = pat_low_ff[gk*8 +: 8];
            end else begin : g_hi
               assign pat_vec[gk*8 +: 8] = pat_high_ff[(gk-8)*8 +: 8];
            end
            assign care_vec[gk] = care_ff[gk];
         end else begin : g_wild
            assign pat_vec[gk*8 +: 8] = 8'd0;
            assign care_vec[gk]       = 1'b0;
         end
      end
      if (MAX_PATTERN_BYTES == 1) begin : g_win1
         assign win_in = in_byte_ff;
      end else begin : g_winn
         assign win_in = {win_ff[WIN_W-9:0], in_byte_ff};
      end
   endgenerate

   // input register
   assign process       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   // compare stage
   always_comb begin
      plen_ext = CL_W'(plen_ff);
      if (plen_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (plen_ext > CL_W'(MAX_PATTERN_BYTES)) begin
         used_len = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         used_len = plen_ext[LEN_W-1:0];
      end
      shift = LEN_W'(MAX_PATTERN_BYTES) - used_len;

      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         win_rev[i*8 +: 8] = win_in[(MAX_PATTERN_BYTES-1-i)*8 +: 8];
      end
      // aligned byte k lines up with pattern byte k
      aligned = win_rev >> {shift, 3'b000};
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         ok_vec[k] = (LEN_W'(k) >= used_len) || !care_vec[k]
                     || (aligned[k*8 +: 8] == pat_vec[k*8 +: 8]);
      end
      hit = &ok_vec;

      seen_in = (&seen_ff) ? seen_ff : seen_ff + POSITION_BITS'(1);
      fire      = !reported_ff && (CMP_W'(seen_in) >= CMP_W'(used_len)) && hit;
      not_found = in_last_ff && !reported_ff && !fire;
      reported_in = reported_ff || fire;
      addr = base_ff + (ADDRESS_WIDTH'(seen_in) - ADDRESS_WIDTH'(used_len))
             + {{(ADDRESS_WIDTH-OFFSET_WIDTH){offs_ff[OFFSET_WIDTH-1]}}, offs_ff};
   end

   // region state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (process) begin
         if (in_last_ff) begin
            seen_ff     <= '0;
            reported_ff <= 1'b0;
         end else begin
            seen_ff     <= seen_in;
            reported_ff <= reported_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         win_ff <= win_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (process && (fire || not_found)) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process && (fire || not_found)) begin
         out_found_ff <= fire;
         out_addr_ff  <= fire ? addr : '0;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.found         = out_found_ff;
   assign rsp_bus.match_address = out_addr_ff;

`ifndef SYNTHESIS
   a_region_clear: assert property (@(posedge clock) disable iff (reset)
      (process && in_last_ff) |=> (seen_ff == '0 && !reported_ff))
      else $error("region state not cleared after last byte");

   a_reported_seen: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> (seen_ff != '0))
      else $error("match reported with empty position count");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !req_bus.ready) |-> (out_valid_ff && !rsp_bus.ready))
      else $error("input stalled without a stalled result");
`endif

endmodule
